FILE: hw/rtl/brtc_pkg.sv
// Shared types and constants for the blank-run to tab converter.
// Holds the byte codes, widths and the command word passed from front to back.
// No dependencies.
package brtc_pkg;

  localparam int MAX_TAB_SIZE = 64;
  localparam int COLUMN_BITS  = 16;
  localparam int TAB_W        = 7;
  localparam int PHASE_W      = 6;
  localparam int CNT_W        = 6;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = 2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;

  localparam logic [TAB_W-1:0] DEFAULT_TAB = 7'd8;
  localparam logic [CNT_W-1:0] PENDING_MAX = 6'd63;

  localparam logic REG_TAB_SIZE    = 1'b0;
  localparam logic REG_CONVERT_ALL = 1'b1;

  // One command: rep_cnt copies of rep_byte, then optionally tail_byte.
  typedef struct packed {
    logic [7:0]       rep_byte;
    logic [CNT_W-1:0] rep_cnt;
    logic             tail_vld;
    logic [7:0]       tail_byte;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Clamp the programmed tab size into 1..MAX_TAB_SIZE.
  function automatic logic [TAB_W-1:0] eff_tab(input logic [TAB_W-1:0] ts);
    logic [TAB_W-1:0] r;
    if (ts == '0) begin
      r = TAB_W'(1);
    end else if (ts > TAB_W'(MAX_TAB_SIZE)) begin
      r = TAB_W'(MAX_TAB_SIZE);
    end else begin
      r = ts;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/brtc_front.sv
// Front end of the blank-run to tab converter: accepts bytes, tracks the line
// state and turns each byte into at most one command word. Uses brtc_pkg.
module brtc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [7:0]                    in_byte,
  input  logic                          in_end_of_input,
  output logic                          full,
  input  logic [brtc_pkg::TAB_W-1:0]    tab_eff,
  input  logic                          convert_all,
  input  logic                          tab_wr,
  input  brtc_pkg::q_stat_t             q_stat,
  output logic                          cmd_vld,
  output brtc_pkg::cmd_t                cmd
);

  localparam int CB = brtc_pkg::COLUMN_BITS;
  localparam int PW = brtc_pkg::PHASE_W;
  localparam int TW = brtc_pkg::TAB_W;
  localparam int NW = brtc_pkg::CNT_W;

  logic [CB-1:0] column_r, column_nxt;
  logic [PW-1:0] phase_r, phase_nxt;
  logic          open_r, open_nxt;
  logic [1:0]    run_r, run_nxt;
  logic          held_r, held_nxt;
  logic          hsr_r, hsr_nxt;
  logic [NW-1:0] pend_r, pend_nxt;
  logic          reduce_r, reduce_nxt;

  logic          accept;
  logic          is_blank;
  logic [TW-1:0] phase_w;
  logic [TW-1:0] adv;
  logic          reached;
  logic [CB:0]   col_sum;
  logic [CB-1:0] col_added;
  logic [PW-1:0] phase_inc;
  logic [NW-1:0] flush_cnt;
  logic [7:0]    flush_byte;

  assign full   = q_stat.full | reduce_r;
  assign accept = push & ~full;

  assign phase_w  = {1'b0, phase_r};
  assign is_blank = (in_byte == brtc_pkg::CH_SPACE) || (in_byte == brtc_pkg::CH_TAB);

  always_comb begin
    adv     = (in_byte == brtc_pkg::CH_TAB) ? (tab_eff - phase_w) : TW'(1);
    col_sum = {1'b0, column_r} + (CB+1)'(adv);
    col_added = col_sum[CB] ? {CB{1'b1}} : col_sum[CB-1:0];
    reached = (in_byte == brtc_pkg::CH_TAB) || ((phase_w + TW'(1)) == tab_eff);
    phase_inc = reached ? '0 : (phase_r + PW'(1));
  end

  // Output of flushing the held run.
  always_comb begin
    flush_byte = brtc_pkg::CH_SPACE;
    flush_cnt  = '0;
    case (run_r)
      2'd1: begin
        flush_byte = held_r ? brtc_pkg::CH_TAB : brtc_pkg::CH_SPACE;
        flush_cnt  = NW'(1);
      end
      2'd2, 2'd3: begin
        flush_cnt = pend_r;
      end
      default: begin
        flush_cnt = '0;
      end
    endcase
  end

  always_comb begin
    column_nxt = column_r;
    phase_nxt  = phase_r;
    open_nxt   = open_r;
    run_nxt    = run_r;
    held_nxt   = held_r;
    hsr_nxt    = hsr_r;
    pend_nxt   = pend_r;
    reduce_nxt = reduce_r;
    cmd        = '0;
    cmd_vld    = 1'b0;

    if (reduce_r) begin
      // Bring the phase below a newly written tab size, one subtract a cycle.
      if (phase_w >= tab_eff) begin
        phase_nxt = PW'(phase_w - tab_eff);
      end else begin
        reduce_nxt = 1'b0;
      end
    end else if (tab_wr) begin
      reduce_nxt = 1'b1;
    end

    if (accept) begin
      if (in_end_of_input) begin
        cmd.rep_byte = flush_byte;
        cmd.rep_cnt  = flush_cnt;
        column_nxt   = '0;
        phase_nxt    = '0;
        open_nxt     = 1'b1;
        run_nxt      = 2'd0;
        held_nxt     = 1'b0;
        hsr_nxt      = 1'b0;
        pend_nxt     = '0;
      end else if (is_blank && open_r) begin
        column_nxt   = col_added;
        phase_nxt    = phase_inc;
        cmd.rep_byte = brtc_pkg::CH_TAB;
        if (run_r == 2'd0) begin
          run_nxt  = 2'd1;
          held_nxt = (in_byte == brtc_pkg::CH_TAB);
          hsr_nxt  = reached;
          pend_nxt = reached ? '0 : NW'(1);
        end else begin
          cmd.rep_cnt = NW'((run_r == 2'd1) && hsr_r) + NW'(reached);
          run_nxt     = 2'd2;
          if (reached) begin
            pend_nxt = '0;
          end else if (pend_r < brtc_pkg::PENDING_MAX) begin
            pend_nxt = pend_r + NW'(1);
          end
        end
      end else begin
        cmd.rep_byte  = flush_byte;
        cmd.rep_cnt   = flush_cnt;
        cmd.tail_vld  = 1'b1;
        cmd.tail_byte = in_byte;
        run_nxt       = 2'd0;
        held_nxt      = 1'b0;
        hsr_nxt       = 1'b0;
        pend_nxt      = '0;
        if (in_byte == brtc_pkg::CH_NL) begin
          column_nxt = '0;
          phase_nxt  = '0;
          open_nxt   = 1'b1;
        end else begin
          if (in_byte == brtc_pkg::CH_BS) begin
            if (column_r != '0) begin
              column_nxt = column_r - CB'(1);
              phase_nxt  = (phase_r == '0) ? PW'(tab_eff - TW'(1)) : (phase_r - PW'(1));
            end
          end else if (in_byte == brtc_pkg::CH_TAB) begin
            column_nxt = col_added;
            phase_nxt  = '0;
          end else begin
            column_nxt = col_added;
            phase_nxt  = phase_inc;
          end
          if (!convert_all) begin
            open_nxt = 1'b0;
          end
        end
      end
      cmd_vld = (cmd.rep_cnt != '0) || cmd.tail_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      phase_r  <= '0;
      open_r   <= 1'b1;
      run_r    <= 2'd0;
      held_r   <= 1'b0;
      hsr_r    <= 1'b0;
      pend_r   <= '0;
      reduce_r <= 1'b0;
    end else begin
      column_r <= column_nxt;
      phase_r  <= phase_nxt;
      open_r   <= open_nxt;
      run_r    <= run_nxt;
      held_r   <= held_nxt;
      hsr_r    <= hsr_nxt;
      pend_r   <= pend_nxt;
      reduce_r <= reduce_nxt;
    end
  end

endmodule

FILE: hw/rtl/brtc_fifo.sv
// Command queue between front and back of the blank-run to tab converter.
// Small register array with head read; uses brtc_pkg.
module brtc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  brtc_pkg::cmd_t    wr_data,
  input  logic              rd,
  output brtc_pkg::cmd_t    rd_data,
  output brtc_pkg::q_stat_t stat
);

  localparam int PW = brtc_pkg::Q_PTR_W;
  localparam int D  = brtc_pkg::Q_DEPTH;

  brtc_pkg::cmd_t mem [D];
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  rp_r, rp_nxt;
  logic [PW:0]    cnt_r, cnt_nxt;
  logic           do_wr, do_rd;

  assign stat.full  = (cnt_r == (PW+1)'(D));
  assign stat.empty = (cnt_r == '0);
  assign do_wr      = wr & ~stat.full;
  assign do_rd      = rd & ~stat.empty;
  assign rd_data    = mem[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? (wp_r + PW'(1)) : wp_r;
    rp_nxt  = do_rd ? (rp_r + PW'(1)) : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(do_wr) - (PW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/brtc_back.sv
// Back end of the blank-run to tab converter: expands queued commands into
// one byte a cycle as pop allows, held in a result reg. Uses brtc_pkg.
module brtc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  brtc_pkg::cmd_t    head,
  input  brtc_pkg::q_stat_t q_stat,
  output logic              q_rd,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_byte,
  output logic              out_last
);

  localparam int NW = brtc_pkg::CNT_W;

  logic [NW-1:0] idx_r, idx_nxt;
  logic          vld_r, vld_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          last_r, last_nxt;
  logic          load;
  logic          in_rep;

  assign empty    = ~vld_r;
  assign out_byte = byte_r;
  assign out_last = last_r;
  assign load     = ~q_stat.empty & (~vld_r | pop);
  assign in_rep   = idx_r < head.rep_cnt;

  always_comb begin
    idx_nxt  = idx_r;
    vld_nxt  = vld_r & ~pop;
    byte_nxt = byte_r;
    last_nxt = last_r;
    q_rd     = 1'b0;
    if (load) begin
      vld_nxt = 1'b1;
      if (in_rep) begin
        byte_nxt = head.rep_byte;
        last_nxt = (idx_r == (head.rep_cnt - NW'(1))) && !head.tail_vld;
      end else begin
        byte_nxt = head.tail_byte;
        last_nxt = 1'b1;
      end
      // Retire the command on its final byte.
      if (last_nxt) begin
        q_rd    = 1'b1;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

endmodule

FILE: hw/rtl/blank_run_to_tab_converter.sv
// Top level of the blank-run to tab converter (unexpand).
// Instantiates brtc_front, brtc_fifo and brtc_back; uses brtc_pkg.
//
// Usage:
//   Input channel: drive in_byte / in_end_of_input with push; a byte is
//   taken on a clock edge with push high and full low. One byte a cycle is
//   accepted while the command queue has room and no phase reduction runs.
//   Result channel: while empty is low, out_byte / out_last show the oldest
//   result; pop high at a clock edge takes it. out_last marks the final
//   byte caused by one input request.
//   Path: a request's command is registered in the command queue and its
//   bytes then in the result register. The back end emits one byte per
//   cycle while pop is high, so a request flushing a long blank run (up
//   to 63 blanks and a tail byte) drains byte by byte; the four-entry
//   command queue absorbs this until it fills, then full is raised.
//   Receiver stall: with pop low the result register holds and the back
//   end waits; the front keeps accepting until the queue is full.
//   Configuration: APB writes at 0 (tab_size) and 4 (convert_all), only
//   while the block is idle. A tab_size write raises full while the column
//   phase is reduced to the new size.
//   Reset (rst_n low, synchronous): registers return to tab size 8,
//   leading-only mode; line state and queue clear.
module blank_run_to_tab_converter (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_input,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TW = brtc_pkg::TAB_W;

  logic [TW-1:0]     tab_size_r, tab_size_nxt;
  logic              conv_all_r, conv_all_nxt;
  logic              cfg_wr;
  logic              tab_wr;
  logic [TW-1:0]     tab_eff;

  logic              cmd_vld;
  brtc_pkg::cmd_t    cmd;
  brtc_pkg::cmd_t    head;
  brtc_pkg::q_stat_t q_stat;
  logic              q_rd;

  // Register file: decode the word address only.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign tab_wr  = cfg_wr && (paddr[2] == brtc_pkg::REG_TAB_SIZE);
  assign tab_eff = brtc_pkg::eff_tab(tab_size_r);

  always_comb begin
    tab_size_nxt = tab_size_r;
    conv_all_nxt = conv_all_r;
    if (cfg_wr) begin
      case (paddr[2])
        brtc_pkg::REG_TAB_SIZE:    tab_size_nxt = pwdata[TW-1:0];
        brtc_pkg::REG_CONVERT_ALL: conv_all_nxt = pwdata[0];
        default:                   tab_size_nxt = tab_size_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      brtc_pkg::REG_TAB_SIZE:    prdata = {{(32-TW){1'b0}}, tab_size_r};
      brtc_pkg::REG_CONVERT_ALL: prdata = {31'd0, conv_all_r};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_size_r <= brtc_pkg::DEFAULT_TAB;
      conv_all_r <= 1'b0;
    end else begin
      tab_size_r <= tab_size_nxt;
      conv_all_r <= conv_all_nxt;
    end
  end

  // Front: classify each byte, update line state, issue up to one command.
  brtc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .full            (full),
    .tab_eff         (tab_eff),
    .convert_all     (conv_all_r),
    .tab_wr          (tab_wr),
    .q_stat          (q_stat),
    .cmd_vld         (cmd_vld),
    .cmd             (cmd)
  );

  // Queue: decouple the one-byte-in front from the many-bytes-out back.
  brtc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (cmd_vld),
    .wr_data (cmd),
    .rd      (q_rd),
    .rd_data (head),
    .stat    (q_stat)
  );

  // Back: expand commands into bytes, hold the result for the receiver.
  brtc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule
